>>> rtl/core/dbl_pkg.sv
// Shared types and constants for the dual biquad lowpass with deadzone hold.
// Holds the register map, coefficient format and the coefficient bundle type.
// Depends on nothing; every other file of the block but dbl_merge refers to it by scoped names.
package dbl_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int COEF_W     = 15;
    localparam int BAND_W     = 16;
    localparam int FRAC_W     = 14;

    localparam logic [CFG_ADDR_W-1:0] CFG_FEEDBACK_ONE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FEEDBACK_TWO     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FEEDFORWARD_GAIN = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEAD_BAND        = 2'd3;

    localparam logic [COEF_W-1:0] RST_FEEDBACK_ONE     = 15'd6054;
    localparam logic [COEF_W-1:0] RST_FEEDBACK_TWO     = 15'd3208;
    localparam logic [COEF_W-1:0] RST_FEEDFORWARD_GAIN = 15'd3384;
    localparam logic [BAND_W-1:0] RST_DEAD_BAND        = 16'd192;

    typedef struct packed {
        logic [COEF_W-1:0] feedback_one;
        logic [COEF_W-1:0] feedback_two;
        logic [COEF_W-1:0] feedforward_gain;
    } t_coefs;

endpackage

>>> rtl/core/dbl_filter.sv
// One lane of the second-order lowpass: input and output history plus the
// combinational multiply-accumulate, floor shift and saturation.
// Depends on dbl_pkg for the coefficient bundle and the fraction width.
module dbl_filter #(
    parameter int SAMPLE_WIDTH = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  dbl_pkg::t_coefs                i_coefs,
    output logic signed [SAMPLE_WIDTH-1:0] o_y
);
    localparam int W  = SAMPLE_WIDTH;
    localparam int AW = W + 19;
    localparam int SW = AW - dbl_pkg::FRAC_W;

    logic signed [W-1:0]  r_x1, r_x2, r_y1, r_y2;
    logic signed [W+1:0]  sum_x;
    logic signed [15:0]   c_fb1, c_fb2, c_ff;
    logic signed [W+15:0] p_fb1, p_fb2;
    logic signed [W+17:0] p_ff;
    logic signed [AW-1:0] acc;
    logic signed [SW-1:0] shifted;
    logic                 ovf;
    logic signed [W-1:0]  n_y;

    assign c_fb1 = $signed({1'b0, i_coefs.feedback_one});
    assign c_fb2 = $signed({1'b0, i_coefs.feedback_two});
    assign c_ff  = $signed({1'b0, i_coefs.feedforward_gain});

    assign sum_x = $signed({{2{i_x[W-1]}}, i_x})
                 + $signed({r_x1[W-1], r_x1, 1'b0})
                 + $signed({{2{r_x2[W-1]}}, r_x2});

    assign p_fb1 = c_fb1 * r_y1;
    assign p_fb2 = c_fb2 * r_y2;
    assign p_ff  = c_ff * sum_x;

    assign acc = $signed({{3{p_fb1[W+15]}}, p_fb1})
               - $signed({{3{p_fb2[W+15]}}, p_fb2})
               + $signed({p_ff[W+17], p_ff});

    assign shifted = acc[AW-1:dbl_pkg::FRAC_W];
    assign ovf     = (|shifted[SW-1:W-1]) && !(&shifted[SW-1:W-1]);

    always_comb begin
        if (ovf) begin
            n_y = shifted[SW-1] ? $signed({1'b1, {(W-1){1'b0}}})
                                : $signed({1'b0, {(W-1){1'b1}}});
        end else begin
            n_y = shifted[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_en) begin
            r_x1 <= i_x;
            r_x2 <= r_x1;
            r_y1 <= n_y;
            r_y2 <= r_y1;
        end
    end

    assign o_y = r_y1;

endmodule

>>> rtl/core/dbl_hold.sv
// One lane of the deadzone hold: keeps the last passed value and replaces it
// only when the new filter output moves by more than the dead band.
// Depends on dbl_pkg for the dead band width.
module dbl_hold #(
    parameter int SAMPLE_WIDTH = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y,
    input  logic [dbl_pkg::BAND_W-1:0]     i_band,
    output logic signed [SAMPLE_WIDTH-1:0] o_held,
    output logic signed [SAMPLE_WIDTH-1:0] o_next
);
    localparam int W  = SAMPLE_WIDTH;
    localparam int CW = W + 1 + dbl_pkg::BAND_W;

    logic signed [W-1:0] r_held;
    logic signed [W:0]   diff;
    logic [W:0]          mag;
    logic                pass;

    assign diff = $signed({i_y[W-1], i_y}) - $signed({r_held[W-1], r_held});
    assign mag  = diff[W] ? $unsigned(-diff) : $unsigned(diff);
    assign pass = {{dbl_pkg::BAND_W{1'b0}}, mag} > {{(CW-dbl_pkg::BAND_W){1'b0}}, i_band};

    assign o_next = pass ? i_y : r_held;
    assign o_held = r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_en) begin
            r_held <= o_next;
        end
    end

endmodule

>>> rtl/core/dbl_merge.sv
// Merging stage: collects the held values of the reported lanes into the
// result item and registers the channel-0 value truncated toward zero.
// Depends on no other file; it uses nothing from dbl_pkg.
module dbl_merge #(
    parameter int SAMPLE_WIDTH = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_move,
    input  logic                           i_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_held_a,
    input  logic signed [SAMPLE_WIDTH-1:0] i_held_b,
    input  logic signed [SAMPLE_WIDTH-1:0] i_next_a,
    output logic                           o_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_clean_a,
    output logic signed [SAMPLE_WIDTH-1:0] o_clean_b,
    output logic signed [SAMPLE_WIDTH-9:0] o_whole_a
);
    localparam int W = SAMPLE_WIDTH;

    logic                r_valid;
    logic signed [W-9:0] r_whole;
    logic signed [W-9:0] n_whole;

    // Floor division by 256 is the upper bits; negative values with a nonzero
    // fraction step one toward zero.
    always_comb begin
        n_whole = i_next_a[W-1:8];
        if (i_next_a[W-1] && (|i_next_a[7:0])) begin
            n_whole = i_next_a[W-1:8] + (W-8)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_move) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_move) begin
            r_whole <= n_whole;
        end
    end

    assign o_valid   = r_valid;
    assign o_clean_a = i_held_a;
    assign o_clean_b = i_held_b;
    assign o_whole_a = r_whole;

endmodule

>>> rtl/core/dual_biquad_lowpass_deadzone.sv
// Dual biquad lowpass with deadzone hold. The block takes one item per clock
// and sustains that rate unless the output stall backs up into o_stall. The
// filter lane's multiply-accumulate, whose feedback on the previous output is
// combinational, finishes at the accepting edge into the filter output register;
// when the filter stage moves, the deadzone compare updates the held value,
// which is also the result register, and the sample's result is offered. Items
// not marked as samples are accepted and give no result.
// Depends on dbl_pkg, dbl_filter, dbl_hold and dbl_merge.
module dual_biquad_lowpass_deadzone #(
    parameter int CHANNELS     = 2,
    parameter int SAMPLE_WIDTH = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_is_sample,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample_a,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample_b,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]     o_clean_a,
    output logic signed [SAMPLE_WIDTH-1:0]     o_clean_b,
    output logic signed [SAMPLE_WIDTH-9:0]     o_whole_a,
    input  logic                               i_cfg_we,
    input  logic [dbl_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [dbl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int W = SAMPLE_WIDTH;

    dbl_pkg::t_coefs                r_coefs;
    logic [dbl_pkg::BAND_W-1:0]     r_band;
    logic                           r_s2_valid;
    logic                           out_free;
    logic                           s2_free;
    logic                           s2_move;
    logic                           in_acc;
    logic                           filt_en;
    logic signed [W-1:0]            lane_x    [CHANNELS];
    logic signed [W-1:0]            lane_y    [CHANNELS];
    logic signed [W-1:0]            lane_held [CHANNELS];
    logic signed [W-1:0]            lane_next [CHANNELS];
    logic signed [W-1:0]            held_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.feedback_one     <= dbl_pkg::RST_FEEDBACK_ONE;
            r_coefs.feedback_two     <= dbl_pkg::RST_FEEDBACK_TWO;
            r_coefs.feedforward_gain <= dbl_pkg::RST_FEEDFORWARD_GAIN;
            r_band                   <= dbl_pkg::RST_DEAD_BAND;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dbl_pkg::CFG_FEEDBACK_ONE: begin
                    r_coefs.feedback_one <= i_cfg_data[dbl_pkg::COEF_W-1:0];
                end
                dbl_pkg::CFG_FEEDBACK_TWO: begin
                    r_coefs.feedback_two <= i_cfg_data[dbl_pkg::COEF_W-1:0];
                end
                dbl_pkg::CFG_FEEDFORWARD_GAIN: begin
                    r_coefs.feedforward_gain <= i_cfg_data[dbl_pkg::COEF_W-1:0];
                end
                dbl_pkg::CFG_DEAD_BAND: begin
                    r_band <= i_cfg_data[dbl_pkg::BAND_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign out_free = !o_valid || !i_stall;
    assign s2_move  = r_s2_valid && out_free;
    assign s2_free  = !r_s2_valid || out_free;
    assign o_stall  = !s2_free;
    assign in_acc   = i_valid && s2_free;
    assign filt_en  = in_acc && i_is_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= filt_en;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++) begin : g_lane
            if (g == 0) begin : g_x_a
                assign lane_x[g] = i_sample_a;
            end else if (g == 1) begin : g_x_b
                assign lane_x[g] = i_sample_b;
            end else begin : g_x_zero
                assign lane_x[g] = '0;
            end

            dbl_filter #(
                .SAMPLE_WIDTH(W)
            ) u_filter (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (filt_en),
                .i_x     (lane_x[g]),
                .i_coefs (r_coefs),
                .o_y     (lane_y[g])
            );

            dbl_hold #(
                .SAMPLE_WIDTH(W)
            ) u_hold (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (s2_move),
                .i_y     (lane_y[g]),
                .i_band  (r_band),
                .o_held  (lane_held[g]),
                .o_next  (lane_next[g])
            );
        end

        if (CHANNELS > 1) begin : g_two
            assign held_b = lane_held[1];
        end else begin : g_one
            assign held_b = '0;
        end
    endgenerate

    dbl_merge #(
        .SAMPLE_WIDTH(W)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_move    (s2_move),
        .i_stall   (i_stall),
        .i_held_a  (lane_held[0]),
        .i_held_b  (held_b),
        .i_next_a  (lane_next[0]),
        .o_valid   (o_valid),
        .o_clean_a (o_clean_a),
        .o_clean_b (o_clean_b),
        .o_whole_a (o_whole_a)
    );

    a_empty_stage_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s2_valid |-> !o_stall)
        else $error("Input stalled while the filter stage is empty.");

    a_blocked_stage_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && o_valid && i_stall) |-> o_stall)
        else $error("Input not stalled while the pipeline is blocked.");

    a_skip_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_is_sample) |=> !r_s2_valid)
        else $error("A non-sample item entered the filter stage.");

    a_move_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_move |=> o_valid)
        else $error("A filtered item did not reach the output.");

endmodule

>>> tb/sv/dbl_lowpass_checker.sv
// Checker for the dual biquad lowpass with deadzone hold: it watches the sample,
// result and register ports, predicts each result and compares it field by field.
// Depends on dbl_pkg for the register map and widths.
`timescale 1ns / 100ps

module dbl_lowpass_checker #(
    parameter int SAMPLE_WIDTH = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic                                i_is_sample,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_a,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_b,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_clean_a,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_clean_b,
    input  logic signed [SAMPLE_WIDTH-9:0]      i_whole_a,
    input  logic                                i_cfg_we,
    input  logic [dbl_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [dbl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_checked
);

    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) <<< (SAMPLE_WIDTH - 1));

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] clean_a;
        logic signed [SAMPLE_WIDTH-1:0] clean_b;
        logic signed [SAMPLE_WIDTH-9:0] whole_a;
    } t_conditioned;

    t_conditioned pending_clean[$];

    logic [dbl_pkg::COEF_W-1:0] fb_one;
    logic [dbl_pkg::COEF_W-1:0] fb_two;
    logic [dbl_pkg::COEF_W-1:0] ff_gain;
    logic [dbl_pkg::BAND_W-1:0] band;

    logic signed [SAMPLE_WIDTH-1:0] x_one [2];
    logic signed [SAMPLE_WIDTH-1:0] x_two [2];
    logic signed [SAMPLE_WIDTH-1:0] y_one [2];
    logic signed [SAMPLE_WIDTH-1:0] y_two [2];
    logic signed [SAMPLE_WIDTH-1:0] hold_val [2];

    int errors  = 0;
    int checked = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    function automatic logic signed [SAMPLE_WIDTH-1:0] lowpass_hold(
        input int ch, input logic signed [SAMPLE_WIDTH-1:0] x);
        longint acc;
        longint y;
        longint diff;
        acc = longint'(fb_one) * longint'(y_one[ch])
            - longint'(fb_two) * longint'(y_two[ch])
            + longint'(ff_gain)
              * (longint'(x) + 2 * longint'(x_one[ch]) + longint'(x_two[ch]));
        y = acc >>> dbl_pkg::FRAC_W;
        if (y > SAT_HI) y = SAT_HI;
        if (y < SAT_LO) y = SAT_LO;
        x_two[ch] = x_one[ch];
        x_one[ch] = x;
        y_two[ch] = y_one[ch];
        y_one[ch] = y[SAMPLE_WIDTH-1:0];
        diff = y - longint'(hold_val[ch]);
        if (diff < 0) diff = -diff;
        if (diff > longint'(band)) hold_val[ch] = y[SAMPLE_WIDTH-1:0];
        return hold_val[ch];
    endfunction

    function automatic int field_differs(input string field, input longint want,
                                         input longint got);
        if (want == got) return 0;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_conditioned want;
        if (!i_rst_n) begin
            fb_one  = dbl_pkg::RST_FEEDBACK_ONE;
            fb_two  = dbl_pkg::RST_FEEDBACK_TWO;
            ff_gain = dbl_pkg::RST_FEEDFORWARD_GAIN;
            band    = dbl_pkg::RST_DEAD_BAND;
            for (int ch = 0; ch < 2; ch++) begin
                x_one[ch]    = '0;
                x_two[ch]    = '0;
                y_one[ch]    = '0;
                y_two[ch]    = '0;
                hold_val[ch] = '0;
            end
            pending_clean.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    dbl_pkg::CFG_FEEDBACK_ONE:     fb_one  = i_cfg_data[dbl_pkg::COEF_W-1:0];
                    dbl_pkg::CFG_FEEDBACK_TWO:     fb_two  = i_cfg_data[dbl_pkg::COEF_W-1:0];
                    dbl_pkg::CFG_FEEDFORWARD_GAIN: ff_gain = i_cfg_data[dbl_pkg::COEF_W-1:0];
                    dbl_pkg::CFG_DEAD_BAND:        band    = i_cfg_data[dbl_pkg::BAND_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_clean.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual %0d %0d %0d",
                             $time, i_clean_a, i_clean_b, i_whole_a);
                end else begin
                    want = pending_clean.pop_front();
                    errors += field_differs("clean_a", want.clean_a, i_clean_a);
                    errors += field_differs("clean_b", want.clean_b, i_clean_b);
                    errors += field_differs("whole_a", want.whole_a, i_whole_a);
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall && i_is_sample) begin
                want.clean_a = lowpass_hold(0, i_sample_a);
                want.clean_b = lowpass_hold(1, i_sample_b);
                want.whole_a = (SAMPLE_WIDTH-8)'(longint'(want.clean_a) / 256);
                pending_clean.push_back(want);
            end
        end
        o_errors  <= errors;
        o_pending <= pending_clean.size();
        o_checked <= checked;
    end

endmodule

>>> tb/sv/tb_dual_biquad_lowpass_deadzone.sv
// Top of the testbench for the dual biquad lowpass with deadzone hold: it drives
// directed and random sample streams and register settings and gives the verdict.
// Depends on dbl_pkg, the block and dbl_lowpass_checker.
`timescale 1ns / 100ps

module tb_dual_biquad_lowpass_deadzone;

    localparam int SW = 20;
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [dbl_pkg::COEF_W-1:0] C_MAX = '1;
    localparam logic [dbl_pkg::BAND_W-1:0] B_MAX = '1;
    localparam int HOLD_CYCLES = 200;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_valid     = 1'b0;
    logic                           o_stall;
    logic                           i_is_sample = 1'b0;
    logic signed [SW-1:0]           i_sample_a  = '0;
    logic signed [SW-1:0]           i_sample_b  = '0;
    logic                           o_valid;
    logic                           i_stall     = 1'b0;
    logic signed [SW-1:0]           o_clean_a;
    logic signed [SW-1:0]           o_clean_b;
    logic signed [SW-9:0]           o_whole_a;
    logic                           i_cfg_we    = 1'b0;
    logic [dbl_pkg::CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [dbl_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    int errors;
    int pending;
    int checked;

    int send_idle = 12;
    int recv_idle = 71;
    bit hold_req  = 1'b0;
    int hold_left = 0;
    int items_sent = 0;
    int samples_sent = 0;
    int settings = 0;
    logic signed [SW-1:0] prev_a = '0;
    logic signed [SW-1:0] prev_b = '0;

    dual_biquad_lowpass_deadzone #(
        .CHANNELS     (2),
        .SAMPLE_WIDTH (SW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_is_sample (i_is_sample),
        .i_sample_a  (i_sample_a),
        .i_sample_b  (i_sample_b),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_clean_a   (o_clean_a),
        .o_clean_b   (o_clean_b),
        .o_whole_a   (o_whole_a),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    dbl_lowpass_checker #(
        .SAMPLE_WIDTH (SW)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_is_sample (i_is_sample),
        .i_sample_a  (i_sample_a),
        .i_sample_b  (i_sample_b),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_clean_a   (o_clean_a),
        .i_clean_b   (o_clean_b),
        .i_whole_a   (o_whole_a),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("[dual_biquad_lowpass_deadzone] ERROR");
        $finish;
    end

    // The long hold-off is counted here so that the sender keeps offering items.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    task automatic offer_item(input logic is_sample, input logic signed [SW-1:0] a,
                              input logic signed [SW-1:0] b);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_is_sample <= is_sample;
        i_sample_a  <= a;
        i_sample_b  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        if (is_sample) begin
            samples_sent++;
            prev_a = a;
            prev_b = b;
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_registers(input logic [dbl_pkg::COEF_W-1:0] f1,
                                  input logic [dbl_pkg::COEF_W-1:0] f2,
                                  input logic [dbl_pkg::COEF_W-1:0] gain,
                                  input logic [dbl_pkg::BAND_W-1:0] dz);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= dbl_pkg::CFG_FEEDBACK_ONE;
        i_cfg_data <= dbl_pkg::CFG_DATA_W'(f1);
        @(posedge i_clk);
        i_cfg_addr <= dbl_pkg::CFG_FEEDBACK_TWO;
        i_cfg_data <= dbl_pkg::CFG_DATA_W'(f2);
        @(posedge i_clk);
        i_cfg_addr <= dbl_pkg::CFG_FEEDFORWARD_GAIN;
        i_cfg_data <= dbl_pkg::CFG_DATA_W'(gain);
        @(posedge i_clk);
        i_cfg_addr <= dbl_pkg::CFG_DEAD_BAND;
        i_cfg_data <= dz;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic signed [SW-1:0] pick_sample(input logic signed [SW-1:0] prev);
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0:       return S_MAX;
                    1:       return S_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return SW'($urandom);
            default: return prev + SW'(int'($urandom_range(2047)) - 1024);
        endcase
    endfunction

    function automatic logic [dbl_pkg::COEF_W-1:0] pick_coef(
        input logic [dbl_pkg::COEF_W-1:0] dflt);
        case ($urandom_range(3))
            0:       return dflt;
            1:       return dbl_pkg::COEF_W'($urandom_range(32767));
            2:       return dbl_pkg::COEF_W'($urandom_range(8191));
            default: return $urandom_range(1) ? C_MAX : '0;
        endcase
    endfunction

    function automatic logic [dbl_pkg::BAND_W-1:0] pick_band();
        case ($urandom_range(3))
            0:       return dbl_pkg::RST_DEAD_BAND;
            1:       return dbl_pkg::BAND_W'($urandom_range(65535));
            2:       return dbl_pkg::BAND_W'($urandom_range(511));
            default: return $urandom_range(1) ? B_MAX : '0;
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients: extremes, non-sample reports and steps inside the band.
        offer_item(1'b1, '0, '0);
        offer_item(1'b1, S_MAX, S_MIN);
        offer_item(1'b0, SW'($urandom), SW'($urandom));
        offer_item(1'b1, S_MAX, S_MIN);
        offer_item(1'b1, S_MIN, S_MAX);
        offer_item(1'b1, '0, '0);
        offer_item(1'b1, 20'sd100, -20'sd100);
        offer_item(1'b1, -20'sd1280, 20'sd1280);
        offer_item(1'b0, S_MAX, S_MIN);
        settle();

        // Strong feedback drives the filter into saturation both ways.
        load_registers(C_MAX, '0, C_MAX, '0);
        repeat (3) offer_item(1'b1, S_MAX, S_MAX);
        repeat (3) offer_item(1'b1, S_MIN, S_MIN);
        settle();

        load_registers(C_MAX, C_MAX, C_MAX, B_MAX);
        offer_item(1'b1, S_MAX, S_MIN);
        offer_item(1'b1, S_MIN, S_MAX);
        settle();

        load_registers('0, '0, '0, '0);
        offer_item(1'b1, S_MAX, S_MIN);
        offer_item(1'b0, '0, '0);
        offer_item(1'b1, 20'sd5, -20'sd5);
        settle();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle = 12;
                    recv_idle = 71;
                end
                1: begin
                    send_idle = 71;
                    recv_idle = 12;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int seg = 0; seg < 2; seg++) begin
                load_registers(pick_coef(dbl_pkg::RST_FEEDBACK_ONE),
                               pick_coef(dbl_pkg::RST_FEEDBACK_TWO),
                               pick_coef(dbl_pkg::RST_FEEDFORWARD_GAIN),
                               pick_band());
                for (int n = 0; n < 125; n++) begin
                    if (phase == 0 && seg == 0 && n == 60) hold_req = 1'b1;
                    offer_item($urandom_range(99) >= 12, pick_sample(prev_a),
                               pick_sample(prev_b));
                end
                settle();
            end
        end

        $display("Sent %0d items (%0d samples) under %0d register settings.",
                 items_sent, samples_sent, settings);
        $display("Checked %0d results across three stall mixes and a %0d-cycle hold-off.",
                 checked, HOLD_CYCLES);
        if (errors == 0) begin
            $display("[dual_biquad_lowpass_deadzone] OK");
        end else begin
            $display("[dual_biquad_lowpass_deadzone] ERROR");
        end
        $finish;
    end

endmodule
